FILE: hw/rtl/i64dm_pkg.sv
// Shared constants, operation codes and control types of the 64-bit divider.
package i64dm_pkg;

	localparam int unsigned DATA_WIDTH = 64;
	localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

	typedef enum logic [1:0] {
		OP_UQUO = 2'd0,
		OP_UREM = 2'd1,
		OP_SQUO = 2'd2,
		OP_SREM = 2'd3
	} op_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_t;

endpackage

FILE: hw/rtl/int64_divide_modulo_core.sv
// Top level of the 64-bit integer divide and modulo core.
//
// Usage: a request enters on the s_ group and carries the operation in
// s_tuser (unsigned quotient, unsigned remainder, signed quotient, signed
// remainder) and both operands in s_tdata. One result leaves on the m_
// group for every request.
// Timing: the magnitudes are formed as the request is accepted, then the
// shared shift-and-subtract unit produces one quotient bit per cycle, and
// the final state applies the sign and loads the output register once free.
// s_tready is low from the acceptance until the result is registered, so
// the core takes no new request while one is in progress.
// Division by zero needs no special path: the quotient magnitude comes out
// all ones and the remainder equals the dividend.
// Back pressure: a result waits in the output register while m_tready is
// low, and the core accepts the next request meanwhile; that request holds
// in its final cycle until the output register is free.
// Reset: arst_n clears the sequencer and the output valid flag at once.
module int64_divide_modulo_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // [63:0] dividend, [127:64] divisor
	input  logic [1:0]   s_tuser,  // [1:0] operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata   // [63:0] result
);

	localparam int unsigned W = i64dm_pkg::DATA_WIDTH;

	i64dm_pkg::ctrl_t ctrl;

	i64dm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctrl     (ctrl)
	);

	i64dm_datapath u_datapath (
		.clk       (clk),
		.ctrl      (ctrl),
		.operation (s_tuser),
		.dividend  (s_tdata[W-1:0]),
		.divisor   (s_tdata[2*W-1:W]),
		.result    (m_tdata)
	);

endmodule

FILE: hw/rtl/i64dm_datapath.sv
// Operand registers and the shared shift-and-subtract unit of the divider.
module i64dm_datapath (
	input  logic                               clk,
	input  i64dm_pkg::ctrl_t                   ctrl,
	input  logic [1:0]                         operation,
	input  logic [i64dm_pkg::DATA_WIDTH-1:0]   dividend,
	input  logic [i64dm_pkg::DATA_WIDTH-1:0]   divisor,
	output logic [i64dm_pkg::DATA_WIDTH-1:0]   result
);

	localparam int unsigned W = i64dm_pkg::DATA_WIDTH;

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] div_q;
	logic         sel_rem_q;
	logic         neg_res_q;
	logic [W-1:0] result_q;

	logic         a_neg;
	logic         b_neg;
	logic         is_signed;
	logic         is_rem;
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W-1:0] shifted;
	logic [W:0]   diff;
	logic         take;
	logic [W-1:0] res_mag;

	assign a_neg = dividend[W-1];
	assign b_neg = divisor[W-1];

	always_comb begin
		unique case (i64dm_pkg::op_t'(operation))
			i64dm_pkg::OP_UQUO: begin
				is_signed = 1'b0;
				is_rem    = 1'b0;
			end
			i64dm_pkg::OP_UREM: begin
				is_signed = 1'b0;
				is_rem    = 1'b1;
			end
			i64dm_pkg::OP_SQUO: begin
				is_signed = 1'b1;
				is_rem    = 1'b0;
			end
			i64dm_pkg::OP_SREM: begin
				is_signed = 1'b1;
				is_rem    = 1'b1;
			end
			default: begin
				is_signed = 1'b0;
				is_rem    = 1'b0;
			end
		endcase
	end

	assign a_mag = (is_signed && a_neg) ? (~dividend + W'(1)) : dividend;
	assign b_mag = (is_signed && b_neg) ? (~divisor + W'(1)) : divisor;

	// The bit shifted out of the partial remainder counts as a carry: with it
	// set, the shifted value always exceeds the divisor.
	assign shifted = {rem_q[W-2:0], quo_q[W-1]};
	assign diff    = {rem_q[W-1], shifted} - {1'b0, div_q};
	assign take    = rem_q[W-1] | ~diff[W];

	assign res_mag = sel_rem_q ? rem_q : quo_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q     <= '0;
			quo_q     <= a_mag;
			div_q     <= b_mag;
			sel_rem_q <= is_rem;
			neg_res_q <= is_signed & (is_rem ? a_neg : (a_neg ^ b_neg));
		end else if (ctrl.step) begin
			rem_q <= take ? diff[W-1:0] : shifted;
			quo_q <= {quo_q[W-2:0], take};
		end
		if (ctrl.finish) begin
			result_q <= neg_res_q ? (~res_mag + W'(1)) : res_mag;
		end
	end

	assign result = result_q;

endmodule

FILE: hw/rtl/i64dm_seq.sv
// Sequencer of the divider: handshakes, step counter and output valid flag.
module i64dm_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output i64dm_pkg::ctrl_t ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIX  = 3'b100
	} state_t;

	state_t                          state_q;
	logic [i64dm_pkg::CNT_W-1:0]     cnt_q;
	logic                            m_tvalid_q;
	logic                            out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = ~m_tvalid_q | m_tready;

	always_comb begin
		ctrl.load   = s_tready & s_tvalid;
		ctrl.step   = (state_q == ST_DIV);
		ctrl.finish = (state_q == ST_FIX) & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == i64dm_pkg::LAST_STEP) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					// The result waits here until the output register is free.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctrl.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: hw/rtl/i64dm_checker.sv
// Port-level checks of the divider core and their attachment to the top level.
module i64dm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata
);

	logic s_acc;

	assign s_acc = s_tvalid & s_tready;

	// The core takes no request while one is being divided.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("request accepted while busy");

	// The quotient loop runs its full length before the core frees up.
	a_full_iteration: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> ##65 !s_tready)
		else $error("core ready before division finished");

	// A new result appears exactly when the core becomes free again.
	a_result_frees_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result delivered without freeing the core");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind int64_divide_modulo_core i64dm_checker u_i64dm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
